// ===== hdl/rvit_pkg.sv =====
package rvit_pkg;

  // Defaults and sizes
  localparam int unsigned DMEM_WORDS_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Item opcodes on the command channel
  localparam logic [1:0] ITEM_EXEC = 2'd0;
  localparam logic [1:0] ITEM_MEM  = 2'd1;
  localparam logic [1:0] ITEM_REG  = 2'd2;

  // Preload index that selects the program counter
  localparam logic [9:0] PC_INDEX = 10'd32;

  // Instruction opcodes
  localparam logic [6:0] OPC_LOAD  = 7'h03;
  localparam logic [6:0] OPC_OPIMM = 7'h13;
  localparam logic [6:0] OPC_JALR  = 7'h67;

  // Canonical NOP (ADDI x0, x0, 0)
  localparam logic [31:0] INSN_NOP = 32'h0000_0013;

  // Upper immediate of SRLI and SRAI
  localparam logic [6:0] SHIFT_UP_LOGIC = 7'h00;
  localparam logic [6:0] SHIFT_UP_ARITH = 7'h20;

  // Return address register, used for the halt check
  localparam logic [4:0] REG_RA = 5'd1;

  // OP-IMM funct3
  localparam logic [2:0] F3_ADDI  = 3'd0;
  localparam logic [2:0] F3_SLLI  = 3'd1;
  localparam logic [2:0] F3_SLTI  = 3'd2;
  localparam logic [2:0] F3_SLTIU = 3'd3;
  localparam logic [2:0] F3_XORI  = 3'd4;
  localparam logic [2:0] F3_SRXI  = 3'd5;
  localparam logic [2:0] F3_ORI   = 3'd6;
  localparam logic [2:0] F3_ANDI  = 3'd7;

  // Load funct3
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  // JALR funct3
  localparam logic [2:0] F3_JALR = 3'd0;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_HALT    = 3'd1,
    STAT_X0      = 3'd2,
    STAT_SHIFT   = 3'd3,
    STAT_ILLEGAL = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    K_FLAG,
    K_MEM_WR,
    K_REG_WR,
    K_PC_WR,
    K_LOAD,
    K_ALU,
    K_JALR
  } kind_t;

  typedef enum logic [3:0] {
    ALU_ADD,
    ALU_SLT,
    ALU_SLTU,
    ALU_XOR,
    ALU_OR,
    ALU_AND,
    ALU_SLL,
    ALU_SRL,
    ALU_SRA
  } alu_t;

  typedef enum logic [1:0] {
    SZ_BYTE,
    SZ_HALF,
    SZ_WORD
  } size_t;

  // Classified item handed from front to back
  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic        adv;
    alu_t        alu;
    size_t       size;
    logic        sext;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [31:0] imm;
    logic [9:0]  pidx;
    logic [31:0] pdata;
  } uop_t;

endpackage

// ===== hdl/rvit_cmd_if.sv =====
interface rvit_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] instruction;
  logic [9:0]  preload_index;
  logic [31:0] preload_data;

  modport source (
    output valid, opcode, instruction, preload_index, preload_data,
    input  ready
  );

  modport sink (
    input  valid, opcode, instruction, preload_index, preload_data,
    output ready
  );
endinterface

// ===== hdl/rvit_rsp_if.sv =====
interface rvit_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        reg_written;
  logic [4:0]  written_index;
  logic [31:0] written_value;
  logic [31:0] next_pc;

  modport source (
    output valid, status, reg_written, written_index, written_value, next_pc,
    input  ready
  );

  modport sink (
    input  valid, status, reg_written, written_index, written_value, next_pc,
    output ready
  );
endinterface

// ===== hdl/rv32i_itype_execute.sv =====
// Channel  Role    Fields
// -------  ------  ------------------------------------------------------
// cmd      sink    opcode, instruction, preload_index, preload_data
// rsp      source  status, reg_written, written_index, written_value, next_pc
//
// One transaction per cycle sustained while rsp stays ready; each result passes through
// the queue and then the result register before it is presented (decode into queue,
// execute into the result register).
// Loads read two data memory words through registered ports; the loaded
// value is forwarded to the next transaction, so no bubbles are inserted.
// Synchronous reset clears registers x0..x31, the PC and all control;
// data memory holds undefined contents until written.
// A stalled rsp holds the result register; the two-entry queue keeps cmd
// accepting until it fills. DMEM_WORDS: power of two.
module rv32i_itype_execute #(
  parameter int unsigned DMEM_WORDS = rvit_pkg::DMEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rvit_cmd_if.sink    cmd,
  rvit_rsp_if.source  rsp
);
  import rvit_pkg::*;

  logic push;
  uop_t push_uop;
  logic full;
  logic pop;
  logic head_valid;
  uop_t head;

  rvit_front u_front (
    .cmd      (cmd),
    .full     (full),
    .push     (push),
    .push_uop (push_uop)
  );

  rvit_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_uop   (push_uop),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  rvit_back #(
    .DMEM_WORDS (DMEM_WORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule

// ===== hdl/rvit_front.sv =====
module rvit_front (
  rvit_cmd_if.sink      cmd,
  input  logic          full,
  output logic          push,
  output rvit_pkg::uop_t push_uop
);
  import rvit_pkg::*;

  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [11:0] imm12;
  logic [6:0]  up;

  assign op    = cmd.instruction[6:0];
  assign rd    = cmd.instruction[11:7];
  assign f3    = cmd.instruction[14:12];
  assign imm12 = cmd.instruction[31:20];
  assign up    = cmd.instruction[31:25];

  // Accept whenever the queue has room
  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

  // Classify the transaction
  always_comb begin
    push_uop        = '0;
    push_uop.kind   = K_FLAG;
    push_uop.status = STAT_OK;
    push_uop.adv    = 1'b0;
    push_uop.alu    = ALU_ADD;
    push_uop.size   = SZ_WORD;
    push_uop.sext   = 1'b0;
    push_uop.rd     = rd;
    push_uop.rs1    = cmd.instruction[19:15];
    push_uop.imm    = {{20{imm12[11]}}, imm12};
    push_uop.pidx   = cmd.preload_index;
    push_uop.pdata  = cmd.preload_data;
    case (cmd.opcode)
      ITEM_MEM: begin
        push_uop.kind = K_MEM_WR;
      end
      ITEM_REG: begin
        if (cmd.preload_index == PC_INDEX) begin
          push_uop.kind = K_PC_WR;
        end else if (cmd.preload_index == '0) begin
          push_uop.status = STAT_X0;
        end else if (cmd.preload_index < PC_INDEX) begin
          push_uop.kind = K_REG_WR;
        end else begin
          push_uop.status = STAT_ILLEGAL;
        end
      end
      ITEM_EXEC: begin
        push_uop.adv = 1'b1;
        if (op == OPC_JALR) begin
          if (f3 != F3_JALR) begin
            push_uop.status = STAT_ILLEGAL;
          end else begin
            push_uop.kind = K_JALR;
          end
        end else if (op != OPC_LOAD && op != OPC_OPIMM) begin
          push_uop.status = STAT_ILLEGAL;
        end else if (cmd.instruction == INSN_NOP) begin
          push_uop.status = STAT_OK;
        end else if (rd == '0) begin
          push_uop.status = STAT_X0;
        end else if (op == OPC_LOAD) begin
          push_uop.kind = K_LOAD;
          case (f3)
            F3_LB: begin
              push_uop.size = SZ_BYTE;
              push_uop.sext = 1'b1;
            end
            F3_LH: begin
              push_uop.size = SZ_HALF;
              push_uop.sext = 1'b1;
            end
            F3_LW: begin
              push_uop.size = SZ_WORD;
            end
            F3_LBU: begin
              push_uop.size = SZ_BYTE;
            end
            F3_LHU: begin
              push_uop.size = SZ_HALF;
            end
            default: begin
              push_uop.kind   = K_FLAG;
              push_uop.status = STAT_ILLEGAL;
            end
          endcase
        end else begin
          push_uop.kind = K_ALU;
          case (f3)
            F3_ADDI:  push_uop.alu = ALU_ADD;
            F3_SLTI:  push_uop.alu = ALU_SLT;
            F3_SLTIU: push_uop.alu = ALU_SLTU;
            F3_XORI:  push_uop.alu = ALU_XOR;
            F3_ORI:   push_uop.alu = ALU_OR;
            F3_ANDI:  push_uop.alu = ALU_AND;
            F3_SLLI:  push_uop.alu = ALU_SLL;
            F3_SRXI: begin
              if (up == SHIFT_UP_LOGIC) begin
                push_uop.alu = ALU_SRL;
              end else if (up == SHIFT_UP_ARITH) begin
                push_uop.alu = ALU_SRA;
              end else begin
                push_uop.kind   = K_FLAG;
                push_uop.status = STAT_SHIFT;
              end
            end
            default: push_uop.alu = ALU_ADD;
          endcase
        end
      end
      default: begin
        push_uop.status = STAT_ILLEGAL;
      end
    endcase
  end

endmodule

// ===== hdl/rvit_queue.sv =====
module rvit_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rvit_pkg::uop_t push_uop,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output rvit_pkg::uop_t head
);
  import rvit_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  uop_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CW'(1);
    end else if (pop && !push) begin
      count_next = count - CW'(1);
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
    end
  end

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_uop;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue pop while empty");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && pop) |=> count == $past(count))
    else $error("queue count moved on simultaneous push and pop");

endmodule

// ===== hdl/rvit_back.sv =====
module rvit_back #(
  parameter int unsigned DMEM_WORDS = rvit_pkg::DMEM_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  rvit_pkg::uop_t head,
  output logic           pop,
  rvit_rsp_if.source     rsp
);
  import rvit_pkg::*;

  localparam int unsigned AW = $clog2(DMEM_WORDS);

  // Architectural state
  logic [31:0] rf [32];
  logic [31:0] pc;
  logic [31:0] dmem [DMEM_WORDS];

  // Execute stage signals
  logic          fwd;
  logic [31:0]   a;
  logic [31:0]   sum;
  logic [31:0]   alu_res;
  logic [31:0]   pc_plus4;
  logic [31:0]   pc_next;
  status_t       e1_status;
  logic          e1_wr;
  logic [4:0]    e1_widx;
  logic [31:0]   e1_wval;
  logic          e1_load;
  logic [AW-1:0] ld_idx0;
  logic [AW-1:0] ld_idx1;
  logic [AW-1:0] st_idx;
  logic [31:0]   pidx_ext;

  // Result stage registers
  logic          e2_valid;
  logic          pend;
  status_t       e2_status;
  logic          e2_wr;
  logic [4:0]    e2_widx;
  logic [31:0]   e2_wval;
  logic [31:0]   e2_pc;
  logic          e2_load;
  size_t         e2_size;
  logic          e2_sext;
  logic [1:0]    e2_off;
  logic [31:0]   rdata0;
  logic [31:0]   rdata1;
  logic [63:0]   ld_wide;
  logic [31:0]   ld_raw;
  logic [31:0]   load_val;

  // Take the next transaction when the result stage frees up
  assign pop = head_valid && (!e2_valid || rsp.ready);

  // Forward a load that has not reached the register file yet
  assign fwd      = pend && (e2_widx == head.rs1);
  assign a        = fwd ? load_val : rf[head.rs1];
  assign sum      = a + head.imm;
  assign pc_plus4 = pc + 32'd4;

  assign ld_idx0  = sum[AW+1:2];
  assign ld_idx1  = ld_idx0 + AW'(1);
  assign pidx_ext = 32'(head.pidx);
  assign st_idx   = pidx_ext[AW-1:0];

  always_comb begin
    case (head.alu)
      ALU_ADD:  alu_res = sum;
      ALU_SLT:  alu_res = {31'b0, $signed(a) < $signed(head.imm)};
      ALU_SLTU: alu_res = {31'b0, a < head.imm};
      ALU_XOR:  alu_res = a ^ head.imm;
      ALU_OR:   alu_res = a | head.imm;
      ALU_AND:  alu_res = a & head.imm;
      ALU_SLL:  alu_res = a << head.imm[4:0];
      ALU_SRL:  alu_res = a >> head.imm[4:0];
      ALU_SRA:  alu_res = 32'($signed(a) >>> head.imm[4:0]);
      default:  alu_res = sum;
    endcase
  end

  // Execute the head transaction
  always_comb begin
    e1_status = STAT_OK;
    e1_wr     = 1'b0;
    e1_widx   = '0;
    e1_wval   = '0;
    e1_load   = 1'b0;
    pc_next   = pc;
    case (head.kind)
      K_FLAG: begin
        e1_status = head.status;
        if (head.adv) begin
          pc_next = pc_plus4;
        end
      end
      K_MEM_WR: begin
        pc_next = pc;
      end
      K_REG_WR: begin
        e1_wr   = 1'b1;
        e1_widx = head.pidx[4:0];
        e1_wval = head.pdata;
      end
      K_PC_WR: begin
        pc_next = head.pdata;
      end
      K_LOAD: begin
        e1_wr   = 1'b1;
        e1_widx = head.rd;
        e1_load = 1'b1;
        pc_next = pc_plus4;
      end
      K_ALU: begin
        e1_wr   = 1'b1;
        e1_widx = head.rd;
        e1_wval = alu_res;
        pc_next = pc_plus4;
      end
      K_JALR: begin
        if (head.rs1 == REG_RA && a == '0) begin
          e1_status = STAT_HALT;
        end else begin
          pc_next = {sum[31:1], 1'b0};
          if (head.rd != '0) begin
            e1_wr   = 1'b1;
            e1_widx = head.rd;
            e1_wval = pc_plus4;
          end
        end
      end
      default: begin
        e1_status = STAT_ILLEGAL;
      end
    endcase
  end

  // Update register file; a newer write wins over the retiring load
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) begin
        rf[i] <= '0;
      end
    end else begin
      if (pend) begin
        rf[e2_widx] <= load_val;
      end
      if (pop && e1_wr && !e1_load) begin
        rf[e1_widx] <= e1_wval;
      end
    end
  end

  // Hold the program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (pop) begin
      pc <= pc_next;
    end
  end

  // Data memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (pop && head.kind == K_MEM_WR) begin
      dmem[st_idx] <= head.pdata;
    end
    if (pop && e1_load) begin
      rdata0 <= dmem[ld_idx0];
      rdata1 <= dmem[ld_idx1];
    end
  end

  // Result stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      e2_valid <= 1'b0;
      pend     <= 1'b0;
    end else begin
      if (pop) begin
        e2_valid <= 1'b1;
      end else if (rsp.ready) begin
        e2_valid <= 1'b0;
      end
      pend <= pop && e1_load;
    end
  end

  // Result stage payload
  always_ff @(posedge clk) begin
    if (pop) begin
      e2_status <= e1_status;
      e2_wr     <= e1_wr;
      e2_widx   <= e1_widx;
      e2_wval   <= e1_wval;
      e2_pc     <= pc_next;
      e2_load   <= e1_load;
      e2_size   <= head.size;
      e2_sext   <= head.sext;
      e2_off    <= sum[1:0];
    end
  end

  // Align and extend load data
  assign ld_wide = {rdata1, rdata0} >> {e2_off, 3'b000};
  assign ld_raw  = ld_wide[31:0];

  always_comb begin
    case (e2_size)
      SZ_BYTE: load_val = {{24{e2_sext & ld_raw[7]}}, ld_raw[7:0]};
      SZ_HALF: load_val = {{16{e2_sext & ld_raw[15]}}, ld_raw[15:0]};
      SZ_WORD: load_val = ld_raw;
      default: load_val = ld_raw;
    endcase
  end

  assign rsp.valid         = e2_valid;
  assign rsp.status        = e2_status;
  assign rsp.reg_written   = e2_wr;
  assign rsp.written_index = e2_widx;
  assign rsp.written_value = e2_load ? load_val : e2_wval;
  assign rsp.next_pc       = e2_pc;

  a_x0_zero: assert property (@(posedge clk) disable iff (rst)
    rf[0] == '0)
    else $error("x0 was written");

  a_halt_keeps_pc: assert property (@(posedge clk) disable iff (rst)
    (pop && e1_status == STAT_HALT) |=> pc == $past(pc))
    else $error("program counter moved on halt");

  a_pend_is_load: assert property (@(posedge clk) disable iff (rst)
    pend |-> (e2_valid && e2_load && e2_wr && e2_widx != '0))
    else $error("pending write without a load in result stage");

  a_no_write_clean: assert property (@(posedge clk) disable iff (rst)
    (e2_valid && !e2_wr) |-> (e2_widx == '0 && e2_wval == '0 && !e2_load))
    else $error("result without write carries register data");

endmodule

// ===== bench/rv32i_itype_execute_check.sv =====
`timescale 1ns / 1ps
module rv32i_itype_execute_check #(
  parameter int unsigned DMEM_WORDS = rvit_pkg::DMEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rvit_cmd_if         cmd,
  rvit_rsp_if         rsp,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned checked
);
  import rvit_pkg::*;

  localparam int unsigned MAX_PRINTS = 40;

  // One retired item as the block should report it
  typedef struct packed {
    status_t     status;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
    logic [31:0] pc;
  } retire_t;

  // Architectural shadow state
  logic [31:0] regs [32];
  logic [31:0] pc;
  logic [31:0] mem [DMEM_WORDS];

  retire_t     retired_q [$];
  int unsigned n_fail;
  int unsigned n_checked;
  int unsigned n_pending;

  assign fail_count = n_fail;
  assign pending    = n_pending;
  assign checked    = n_checked;

  initial begin
    n_fail    = 0;
    n_checked = 0;
    n_pending = 0;
  end

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    if (n_fail < MAX_PRINTS) begin
      $display("%0t ns: result %0d: %s is %h, predicted %h", $time, n_checked, field, got,
               want);
    end
    n_fail++;
  endtask

  // Little-endian read of nbytes starting at any byte address, wrapping the memory
  function automatic logic [31:0] load_le(input logic [31:0] addr, input int unsigned nbytes);
    logic [31:0] v;
    logic [31:0] w;
    logic [31:0] ba;
    v = '0;
    for (int unsigned i = 0; i < nbytes; i++) begin
      ba = addr + i;
      w  = mem[(ba >> 2) % DMEM_WORDS];
      v  = v | (((w >> (8 * ba[1:0])) & 32'hFF) << (8 * i));
    end
    return v;
  endfunction

  // Apply one command to the shadow state and return what it retires
  function automatic retire_t retire_item(input logic [1:0] op, input logic [31:0] ins,
                                          input logic [9:0] pidx, input logic [31:0] pdata);
    retire_t     o;
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [2:0]  f3;
    logic [11:0] imm12;
    logic [31:0] imm;
    logic [31:0] a;
    logic [31:0] res;
    logic [31:0] nxt;
    logic [4:0]  sh;
    o        = '0;
    o.status = STAT_OK;
    res      = '0;
    case (op)
      ITEM_MEM: begin
        mem[pidx % DMEM_WORDS] = pdata;
      end
      ITEM_REG: begin
        if (pidx == PC_INDEX) begin
          pc = pdata;
        end else if (pidx == 10'd0) begin
          o.status = STAT_X0;
        end else if (pidx < 10'd32) begin
          regs[pidx[4:0]] = pdata;
          o.wr  = 1'b1;
          o.idx = pidx[4:0];
          o.val = pdata;
        end else begin
          o.status = STAT_ILLEGAL;
        end
      end
      ITEM_EXEC: begin
        opc   = ins[6:0];
        rd    = ins[11:7];
        f3    = ins[14:12];
        rs1   = ins[19:15];
        imm12 = ins[31:20];
        imm   = {{20{imm12[11]}}, imm12};
        sh    = imm12[4:0];
        a     = regs[rs1];
        nxt   = pc + 32'd4;
        if (opc == OPC_JALR) begin
          if (f3 != F3_JALR) begin
            o.status = STAT_ILLEGAL;
          end else if (rs1 == REG_RA && a == 32'd0) begin
            // halt: nothing moves, not even the PC
            o.status = STAT_HALT;
            nxt      = pc;
          end else begin
            nxt = (a + imm) & ~32'd1;
            if (rd != 5'd0) begin
              regs[rd] = pc + 32'd4;
              o.wr     = 1'b1;
              o.idx    = rd;
              o.val    = pc + 32'd4;
            end
          end
        end else if (opc != OPC_LOAD && opc != OPC_OPIMM) begin
          o.status = STAT_ILLEGAL;
        end else if (ins == INSN_NOP) begin
          o.status = STAT_OK;
        end else if (rd == 5'd0) begin
          o.status = STAT_X0;
        end else begin
          if (opc == OPC_LOAD) begin
            case (f3)
              F3_LB: begin
                res = load_le(a + imm, 1);
                res = {{24{res[7]}}, res[7:0]};
              end
              F3_LH: begin
                res = load_le(a + imm, 2);
                res = {{16{res[15]}}, res[15:0]};
              end
              F3_LW:   res = load_le(a + imm, 4);
              F3_LBU:  res = load_le(a + imm, 1);
              F3_LHU:  res = load_le(a + imm, 2);
              default: o.status = STAT_ILLEGAL;
            endcase
          end else begin
            case (f3)
              F3_ADDI:  res = a + imm;
              F3_SLTI:  res = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
              F3_SLTIU: res = (a < imm) ? 32'd1 : 32'd0;
              F3_XORI:  res = a ^ imm;
              F3_ORI:   res = a | imm;
              F3_ANDI:  res = a & imm;
              F3_SLLI:  res = a << sh;
              default: begin
                if (imm12[11:5] == SHIFT_UP_LOGIC) begin
                  res = a >> sh;
                end else if (imm12[11:5] == SHIFT_UP_ARITH) begin
                  res = $unsigned($signed(a) >>> sh);
                end else begin
                  o.status = STAT_SHIFT;
                end
              end
            endcase
          end
          if (o.status == STAT_OK) begin
            regs[rd] = res;
            o.wr     = 1'b1;
            o.idx    = rd;
            o.val    = res;
          end
        end
        pc = nxt;
      end
      default: begin
        o.status = STAT_ILLEGAL;
      end
    endcase
    regs[0] = '0;
    o.pc    = pc;
    return o;
  endfunction

  // Check retired results, then predict newly accepted commands
  always @(posedge clk) begin
    retire_t want;
    if (rst) begin
      for (int i = 0; i < 32; i++) regs[i] = '0;
      pc = '0;
      retired_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (retired_q.size() == 0) begin
          report("unexpected result, next_pc", rsp.next_pc, 32'd0);
        end else begin
          want = retired_q.pop_front();
          if (rsp.status !== want.status) begin
            report("status", 32'(rsp.status), 32'(want.status));
          end
          if (rsp.reg_written !== want.wr) begin
            report("reg_written", 32'(rsp.reg_written), 32'(want.wr));
          end
          if (rsp.written_index !== want.idx) begin
            report("written_index", 32'(rsp.written_index), 32'(want.idx));
          end
          if (rsp.written_value !== want.val) begin
            report("written_value", rsp.written_value, want.val);
          end
          if (rsp.next_pc !== want.pc) report("next_pc", rsp.next_pc, want.pc);
          n_checked++;
        end
      end
      if (cmd.valid && cmd.ready) begin
        retired_q.push_back(retire_item(cmd.opcode, cmd.instruction, cmd.preload_index,
                                        cmd.preload_data));
      end
    end
    n_pending = retired_q.size();
  end

endmodule

// ===== bench/rv32i_itype_execute_test.sv =====
`timescale 1ns / 1ps
module rv32i_itype_execute_test;
  import rvit_pkg::*;

  localparam int unsigned DMEM_WORDS   = DMEM_WORDS_DEF;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned QUIET_FIRST  = 60;
  localparam int unsigned QUIET_LAST   = 140;
  localparam int unsigned IDLE_PCT     = 34;

  // Codes the package does not name
  localparam logic [1:0] ITEM_BAD    = 2'd3;
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [2:0] F3_LOAD_BAD = 3'd3;
  localparam logic [2:0] F3_JALR_BAD = 3'd1;
  localparam logic [6:0] SHIFT_UP_BAD = 7'h10;

  logic        clk;
  logic        rst;
  logic        quiet;
  int unsigned n_insn;
  int unsigned n_preload;
  int unsigned n_bad;
  int unsigned fails;
  int unsigned outstanding;
  int unsigned checked;

  rvit_cmd_if cmd_ch ();
  rvit_rsp_if rsp_ch ();

  rv32i_itype_execute #(
    .DMEM_WORDS(DMEM_WORDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  rv32i_itype_execute_check #(
    .DMEM_WORDS(DMEM_WORDS)
  ) chk (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .fail_count(fails),
    .pending(outstanding),
    .checked(checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Stall the result side at random outside the quiet stretch
  always @(posedge clk) begin
    rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic logic [31:0] itype(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  // Mostly well-formed I-type words with random content, some raw noise
  function automatic logic [31:0] random_insn();
    logic [11:0] imm;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [2:0]  f3;
    int unsigned pick;
    imm  = 12'($urandom);
    rd   = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom);
    rs1  = ($urandom_range(0, 9) == 0) ? REG_RA : 5'($urandom);
    f3   = 3'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if ((f3 == F3_SLLI || f3 == F3_SRXI) && $urandom_range(0, 4) != 0) begin
        imm[11:5] = $urandom_range(0, 1) ? SHIFT_UP_ARITH : SHIFT_UP_LOGIC;
      end
      return itype(imm, rs1, f3, rd, OPC_OPIMM);
    end
    if (pick < 65) begin
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 4))
          0:       f3 = F3_LB;
          1:       f3 = F3_LH;
          2:       f3 = F3_LW;
          3:       f3 = F3_LBU;
          default: f3 = F3_LHU;
        endcase
      end
      return itype(imm, rs1, f3, rd, OPC_LOAD);
    end
    if (pick < 80) begin
      return itype(imm, rs1, ($urandom_range(0, 6) == 0) ? f3 : F3_JALR, rd, OPC_JALR);
    end
    if (pick < 84) return INSN_NOP;
    return $urandom;
  endfunction

  // Present one transaction, idling first at random, and hold until accepted
  task automatic send_item(input logic [1:0] op, input logic [31:0] ins,
                           input logic [9:0] pidx, input logic [31:0] pdata);
    if (!quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.opcode        <= op;
    cmd_ch.instruction   <= ins;
    cmd_ch.preload_index <= pidx;
    cmd_ch.preload_data  <= pdata;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    case (op)
      ITEM_EXEC:          n_insn++;
      ITEM_MEM, ITEM_REG: n_preload++;
      default:            n_bad++;
    endcase
  endtask

  task automatic send_exec(input logic [31:0] ins);
    send_item(ITEM_EXEC, ins, 10'($urandom), $urandom);
  endtask

  initial begin
    int unsigned pick;
    logic [9:0]  ridx;
    rst                  = 1'b1;
    quiet                = 1'b0;
    n_insn               = 0;
    n_preload            = 0;
    n_bad                = 0;
    cmd_ch.valid         = 1'b0;
    cmd_ch.opcode        = ITEM_EXEC;
    cmd_ch.instruction   = '0;
    cmd_ch.preload_index = '0;
    cmd_ch.preload_data  = '0;
    rsp_ch.ready         = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Fill all of data memory so every load reads a written word
    for (int unsigned w = 0; w < DMEM_WORDS; w++) begin
      send_item(ITEM_MEM, $urandom, 10'(w), $urandom);
    end

    // Directed: halt on zero ra, NOP, preload corners
    send_exec(itype(12'h000, REG_RA, F3_JALR, 5'd5, OPC_JALR));
    send_exec(INSN_NOP);
    send_item(ITEM_REG, $urandom, 10'd2, 32'h8000_0000);
    send_item(ITEM_REG, $urandom, 10'd3, 32'hFFFF_FFFF);
    send_item(ITEM_REG, $urandom, 10'd0, 32'h0000_1234);
    send_item(ITEM_REG, $urandom, 10'h3FF, $urandom);
    send_item(ITEM_REG, $urandom, PC_INDEX, 32'hFFFF_FFF8);
    // Directed: every ALU op at immediate and operand extremes
    send_exec(itype(12'h800, 5'd3, F3_ADDI, 5'd4, OPC_OPIMM));
    send_exec(itype(12'h7FF, 5'd2, F3_ADDI, 5'd4, OPC_OPIMM));
    send_exec(itype(12'h000, 5'd2, F3_SLTI, 5'd6, OPC_OPIMM));
    send_exec(itype(12'hFFF, 5'd2, F3_SLTIU, 5'd7, OPC_OPIMM));
    send_exec(itype(12'h7FF, 5'd3, F3_XORI, 5'd8, OPC_OPIMM));
    send_exec(itype(12'h800, 5'd2, F3_ORI, 5'd9, OPC_OPIMM));
    send_exec(itype(12'h555, 5'd3, F3_ANDI, 5'd10, OPC_OPIMM));
    send_exec(itype(12'hFFF, 5'd3, F3_SLLI, 5'd11, OPC_OPIMM));
    send_exec(itype({SHIFT_UP_LOGIC, 5'd31}, 5'd2, F3_SRXI, 5'd12, OPC_OPIMM));
    send_exec(itype({SHIFT_UP_ARITH, 5'd31}, 5'd2, F3_SRXI, 5'd13, OPC_OPIMM));
    send_exec(itype({SHIFT_UP_BAD, 5'd3}, 5'd2, F3_SRXI, 5'd13, OPC_OPIMM));
    send_exec(itype(12'h005, 5'd3, F3_ADDI, 5'd0, OPC_OPIMM));
    // Directed: loads across a word boundary and across the memory wrap
    send_exec(itype(12'h003, 5'd0, F3_LB, 5'd14, OPC_LOAD));
    send_exec(itype(12'h003, 5'd0, F3_LH, 5'd15, OPC_LOAD));
    send_exec(itype(12'hFFF, 5'd3, F3_LW, 5'd16, OPC_LOAD));
    send_exec(itype(12'hFFF, 5'd3, F3_LBU, 5'd17, OPC_LOAD));
    send_exec(itype(12'h7FF, 5'd2, F3_LHU, 5'd18, OPC_LOAD));
    send_exec(itype(12'h000, 5'd2, F3_LOAD_BAD, 5'd19, OPC_LOAD));
    // Directed: jumps and illegal encodings
    send_exec(itype(12'h000, 5'd2, F3_JALR_BAD, 5'd20, OPC_JALR));
    send_exec(itype(12'h005, 5'd3, F3_JALR, 5'd0, OPC_JALR));
    send_exec(itype(12'h000, 5'd2, F3_JALR, REG_RA, OPC_JALR));
    send_exec(itype(12'h000, 5'd2, F3_ADDI, 5'd21, OPC_OP));
    send_item(ITEM_BAD, $urandom, 10'($urandom), $urandom);

    // Random mix, with one stretch where neither side idles
    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      quiet <= (k >= QUIET_FIRST && k < QUIET_LAST);
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_exec(random_insn());
      end else if (pick < 82) begin
        send_item(ITEM_MEM, $urandom, 10'($urandom), $urandom);
      end else if (pick < 96) begin
        case ($urandom_range(0, 19))
          0, 1:    ridx = 10'($urandom);
          2, 3, 4: ridx = 10'(REG_RA);
          default: ridx = 10'($urandom_range(0, 32));
        endcase
        send_item(ITEM_REG, $urandom, ridx, ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom);
      end else begin
        send_item(ITEM_BAD, $urandom, 10'($urandom), $urandom);
      end
    end
    cmd_ch.valid <= 1'b0;
    quiet        <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d transactions: %0d instructions, %0d preloads, %0d bad item codes",
             n_insn + n_preload + n_bad, n_insn, n_preload, n_bad);
    $display("Compared %0d results field by field, %0d mismatches", checked, fails);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rvit_pkg.sv
hdl/rvit_cmd_if.sv
hdl/rvit_rsp_if.sv
hdl/rvit_front.sv
hdl/rvit_queue.sv
hdl/rvit_back.sv
hdl/rv32i_itype_execute.sv
bench/rv32i_itype_execute_check.sv
bench/rv32i_itype_execute_test.sv
